FILE: hdl/clc_pkg.sv
package clc_pkg;

   localparam int MaxResults = 6;
   localparam int QueueDepth = 4;

   localparam logic [7:0] ChrTab      = 8'd9;
   localparam logic [7:0] ChrNewline  = 8'd10;
   localparam logic [7:0] ChrVtab     = 8'd11;
   localparam logic [7:0] ChrFormfeed = 8'd12;
   localparam logic [7:0] ChrSpace    = 8'h20;
   localparam logic [7:0] ChrDquote   = 8'h22;
   localparam logic [7:0] ChrSquote   = 8'h27;
   localparam logic [7:0] ChrStar     = 8'h2a;
   localparam logic [7:0] ChrSlash    = 8'h2f;
   localparam logic [7:0] ChrQuestion = 8'h3f;
   localparam logic [7:0] ChrBslash   = 8'h5c;

   typedef enum logic [1:0] {
      ERR_NONE    = 2'd0,
      ERR_LITERAL = 2'd1,
      ERR_ESCAPE  = 2'd2,
      ERR_COMMENT = 2'd3
   } err_type;

   typedef enum logic [3:0] {
      MODE_NORMAL  = 4'd0,
      MODE_LITERAL = 4'd1,
      MODE_ESC     = 4'd2,
      MODE_HEX     = 4'd3,
      MODE_OCT     = 4'd4,
      MODE_COMMENT = 4'd5,
      MODE_STAR    = 4'd6
   } mode_type;

   typedef struct packed {
      logic [1:0] qcount;
      logic       bs_held;
      mode_type   mode;
      logic [7:0] quote;
      logic [1:0] oct;
      logic       space;
      logic       slash;
   } lex_state_type;

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      err_type    err;
   } result_type;

   typedef struct packed {
      logic [2:0]                      cnt;
      result_type [MaxResults-1:0]     res;
   } bundle_type;

   typedef struct packed {
      lex_state_type st;
      bundle_type    bun;
   } work_type;

   function automatic work_type put(work_type w, logic [7:0] b, logic h, err_type e);
      work_type r;
      r = w;
      if (w.bun.cnt < 3'(MaxResults)) begin
         r.bun.res[w.bun.cnt].data = h ? b : 8'd0;
         r.bun.res[w.bun.cnt].has  = h;
         r.bun.res[w.bun.cnt].err  = e;
         r.bun.cnt = w.bun.cnt + 3'd1;
      end
      return r;
   endfunction

   function automatic work_type flush_normal(work_type w);
      work_type r;
      r = w;
      if (r.st.space) begin
         r = put(r, ChrSpace, 1'b1, ERR_NONE);
         r.st.space = 1'b0;
      end
      if (r.st.slash) begin
         r = put(r, ChrSlash, 1'b1, ERR_NONE);
         r.st.slash = 1'b0;
      end
      return r;
   endfunction

   function automatic work_type lex_literal(work_type w, logic [7:0] c);
      work_type r;
      r = w;
      if (c == r.st.quote) begin
         r = put(r, c, 1'b1, ERR_NONE);
         r.st.mode = MODE_NORMAL;
      end else if (c == ChrBslash) begin
         r = put(r, c, 1'b1, ERR_NONE);
         r.st.mode = MODE_ESC;
      end else if (c == ChrNewline) begin
         r = put(r, c, 1'b1, ERR_LITERAL);
         r.st.mode = MODE_NORMAL;
      end else begin
         r = put(r, c, 1'b1, ERR_NONE);
      end
      return r;
   endfunction

   function automatic work_type lex_escape(work_type w, logic [7:0] c);
      work_type r;
      r = w;
      case (c) inside
         ChrDquote, ChrSquote, ChrQuestion, ChrBslash, "a", "b", "f", "l", "n", "r", "t",
         "v": begin
            r = put(r, c, 1'b1, ERR_NONE);
            r.st.mode = MODE_LITERAL;
         end
         "x": begin
            r = put(r, c, 1'b1, ERR_NONE);
            r.st.mode = MODE_HEX;
         end
         ChrNewline: begin
            r = put(r, c, 1'b1, ERR_LITERAL);
            r.st.mode = MODE_NORMAL;
         end
         ["0":"7"]: begin
            r = put(r, c, 1'b1, ERR_NONE);
            r.st.oct = 2'd1;
            r.st.mode = MODE_OCT;
         end
         default: begin
            r = put(r, c, 1'b1, ERR_ESCAPE);
            r.st.mode = MODE_LITERAL;
         end
      endcase
      return r;
   endfunction

   function automatic work_type lex_normal(work_type w, logic [7:0] c);
      work_type r;
      logic     done;
      r = w;
      done = 1'b0;
      if (r.st.slash) begin
         if (c == ChrStar) begin
            r.st.slash = 1'b0;
            r.st.space = 1'b1;
            r.st.mode = MODE_COMMENT;
            done = 1'b1;
         end else begin
            r = flush_normal(r);
         end
      end
      if (!done) begin
         if (c == ChrSpace) begin
            r.st.space = 1'b1;
         end else if (c == ChrSlash) begin
            r.st.slash = 1'b1;
         end else begin
            r = flush_normal(r);
            r = put(r, c, 1'b1, ERR_NONE);
            if (c == ChrDquote || c == ChrSquote) begin
               r.st.quote = c;
               r.st.mode = MODE_LITERAL;
            end
         end
      end
      return r;
   endfunction

   function automatic logic is_hex(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic work_type lex(work_type w, logic [7:0] c_raw);
      work_type   r;
      logic [7:0] c;
      r = w;
      c = c_raw;
      if (c == ChrTab || c == ChrVtab || c == ChrFormfeed) c = ChrSpace;
      case (r.st.mode)
         MODE_LITERAL: r = lex_literal(r, c);
         MODE_ESC:     r = lex_escape(r, c);
         MODE_HEX: begin
            if (is_hex(c)) begin
               r = put(r, c, 1'b1, ERR_NONE);
            end else begin
               r.st.mode = MODE_LITERAL;
               r = lex_literal(r, c);
            end
         end
         MODE_OCT: begin
            if (c >= "0" && c <= "7" && r.st.oct < 2'd3) begin
               r = put(r, c, 1'b1, ERR_NONE);
               r.st.oct = r.st.oct + 2'd1;
               if (r.st.oct == 2'd3) r.st.mode = MODE_LITERAL;
            end else begin
               r.st.mode = MODE_LITERAL;
               r = lex_literal(r, c);
            end
         end
         MODE_COMMENT: begin
            if (c == ChrStar) r.st.mode = MODE_STAR;
         end
         MODE_STAR: begin
            if (c == ChrSlash) r.st.mode = MODE_NORMAL;
            else if (c != ChrStar) r.st.mode = MODE_COMMENT;
         end
         default: begin
            r.st.mode = MODE_NORMAL;
            r = lex_normal(r, c);
         end
      endcase
      return r;
   endfunction

   function automatic work_type splice(work_type w, logic [7:0] c);
      work_type r;
      logic     done;
      r = w;
      done = 1'b0;
      if (r.st.bs_held) begin
         if (c == ChrNewline) begin
            r.st.bs_held = 1'b0;
            done = 1'b1;
         end else begin
            r = lex(r, ChrBslash);
            if (c == ChrBslash) done = 1'b1;
            else r.st.bs_held = 1'b0;
         end
      end
      if (!done) begin
         if (c == ChrBslash) r.st.bs_held = 1'b1;
         else r = lex(r, c);
      end
      return r;
   endfunction

   function automatic work_type flush_questions(work_type w);
      work_type r;
      r = w;
      for (int i = 0; i < 2; i++) begin
         if (r.st.qcount != 2'd0) begin
            r = splice(r, ChrQuestion);
            r.st.qcount = r.st.qcount - 2'd1;
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] trigraph_map(logic [7:0] c);
      logic [7:0] m;
      case (c)
         "=":       m = "#";
         ChrSlash:  m = ChrBslash;
         ChrSquote: m = "^";
         "(":       m = "[";
         ")":       m = "]";
         "!":       m = "|";
         "<":       m = "{";
         ">":       m = "}";
         "-":       m = "~";
         default:   m = 8'd0;
      endcase
      return m;
   endfunction

   function automatic work_type step(lex_state_type st, logic te, logic [7:0] c, logic e);
      work_type   w;
      logic [7:0] rep;
      w.st = st;
      w.bun = '0;
      rep = trigraph_map(c);
      if (e) begin
         w = flush_questions(w);
         w.st.bs_held = 1'b0;
         if (w.st.mode == MODE_NORMAL) w = flush_normal(w);
         if (w.st.mode == MODE_COMMENT || w.st.mode == MODE_STAR)
            w = put(w, 8'd0, 1'b0, ERR_COMMENT);
         else if (w.st.mode != MODE_NORMAL)
            w = put(w, 8'd0, 1'b0, ERR_LITERAL);
         w.st = '0;
      end else if (te && c == ChrQuestion) begin
         if (w.st.qcount < 2'd2) w.st.qcount = w.st.qcount + 2'd1;
         else w = splice(w, ChrQuestion);
      end else if (te && w.st.qcount == 2'd2 && rep != 8'd0) begin
         w.st.qcount = 2'd0;
         w = splice(w, rep);
      end else begin
         w = flush_questions(w);
         w = splice(w, c);
      end
      return w;
   endfunction

endpackage

FILE: hdl/clc_front.sv
module clc_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_take,
   input  logic [7:0]            req_in_byte,
   input  logic                  req_is_end,
   input  logic                  csr_valid,
   input  logic                  csr_data,
   output logic                  q_push,
   output clc_pkg::bundle_type   q_data
);

   clc_pkg::lex_state_type st_ff, st_in;
   logic                   te_ff, te_in;
   clc_pkg::work_type      w;

   always_comb begin
      w = clc_pkg::step(st_ff, te_ff, req_in_byte, req_is_end);
      st_in = req_take ? w.st : st_ff;
      te_in = csr_valid ? csr_data : te_ff;
   end

   assign q_push = req_take && (w.bun.cnt != 3'd0);
   assign q_data = w.bun;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '0;
         te_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         te_ff <= te_in;
      end
   end

endmodule

FILE: hdl/clc_queue.sv
module clc_queue #(
   parameter int Depth = clc_pkg::QueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_push,
   input  clc_pkg::bundle_type q_data,
   input  logic                q_pop,
   output clc_pkg::bundle_type q_head,
   output logic                q_full,
   output logic                q_empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   clc_pkg::bundle_type mem_ff [Depth];
   logic [PtrW-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (q_push) wr_in = (wr_ff == PtrW'(Depth - 1)) ? '0 : wr_ff + 1'b1;
      if (q_pop)  rd_in = (rd_ff == PtrW'(Depth - 1)) ? '0 : rd_ff + 1'b1;
      if (q_push && !q_pop) cnt_in = cnt_ff + 1'b1;
      else if (!q_push && q_pop) cnt_in = cnt_ff - 1'b1;
   end

   assign q_full  = (cnt_ff == CntW'(Depth));
   assign q_empty = (cnt_ff == '0);
   assign q_head  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (q_push) mem_ff[wr_ff] <= q_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: hdl/clc_back.sv
module clc_back (
   input  logic                clock,
   input  logic                reset,
   input  clc_pkg::bundle_type q_head,
   input  logic                q_empty,
   output logic                q_pop,
   output logic                empty,
   input  logic                pop,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_has_byte,
   output logic [1:0]          rsp_error_code,
   output logic                rsp_last
);

   logic [2:0]          idx_ff, idx_in;
   clc_pkg::result_type cur;
   logic                take;

   // walk the results of the head request one at a time
   assign cur            = q_head.res[idx_ff];
   assign empty          = q_empty;
   assign rsp_out_byte   = cur.data;
   assign rsp_has_byte   = cur.has;
   assign rsp_error_code = cur.err;
   assign rsp_last       = (idx_ff == q_head.cnt - 3'd1);
   assign take           = pop && !q_empty;
   assign q_pop          = take && rsp_last;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = rsp_last ? 3'd0 : idx_ff + 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= 3'd0;
      else idx_ff <= idx_in;
   end

endmodule

FILE: hdl/c_source_lexical_cleaner_core.sv
// Cleans C source one byte per request: optional trigraphs, backslash-newline splicing,
// whitespace mapping, block comment removal and space collapsing, with literal and
// escape checks. A request is taken every cycle while the result queue has room; a
// request yields zero to six results, delivered one per cycle from the queue head while
// pop is held, so sustained rate is one request per cycle when each yields at most one
// result, and one result per cycle otherwise. is_end flushes held bytes and reports open
// comments or literals. Configuration writes are always ready.
module c_source_lexical_cleaner_core #(
   parameter int QueueDepth = clc_pkg::QueueDepth
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_is_end,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);

   clc_pkg::bundle_type q_data, q_head;
   logic                q_push, q_pop, q_full, q_empty, req_take;

   assign full      = q_full;
   assign req_take  = push && !q_full;
   assign csr_ready = 1'b1;

   clc_front u_front (
      .clock, .reset, .req_take, .req_in_byte, .req_is_end,
      .csr_valid, .csr_data, .q_push, .q_data
   );

   clc_queue #(.Depth(QueueDepth)) u_queue (
      .clock, .reset, .q_push, .q_data, .q_pop, .q_head, .q_full, .q_empty
   );

   clc_back u_back (
      .clock, .reset, .q_head, .q_empty, .q_pop, .empty, .pop,
      .rsp_out_byte, .rsp_has_byte, .rsp_error_code, .rsp_last
   );

`ifndef SYNTHESIS
   a_push_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_data.cnt != 3'd0 && q_data.cnt <= 3'd6))
      else $error("empty or oversized bundle queued");
   a_nobyte_end: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_has_byte) |-> (rsp_last &&
      (rsp_error_code == clc_pkg::ERR_LITERAL || rsp_error_code == clc_pkg::ERR_COMMENT)))
      else $error("byteless result not final end report");
   a_head_bounded: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (q_head.cnt != 3'd0))
      else $error("queue head holds no results");
`endif

endmodule

FILE: sim/c_source_lexical_cleaner_core_test.sv
`timescale 1ns / 1ps

module c_source_lexical_cleaner_core_test;

   typedef struct packed {
      logic [7:0]       data;
      logic             has;
      clc_pkg::err_type err;
      logic             last;
   } clean_out_t;

   typedef struct {
      logic [7:0] in_byte;
      logic       is_end;
      logic       pinned;
      clean_out_t pin;
   } stim_row_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       push = 1'b0;
   logic [7:0] req_in_byte = 8'd0;
   logic       req_is_end = 1'b0;
   logic       pop = 1'b0;
   logic       csr_valid = 1'b0;
   logic       csr_data = 1'b0;
   logic       full, empty, csr_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte, rsp_last;
   logic [1:0] rsp_error_code;

   c_source_lexical_cleaner_core dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_in_byte(req_in_byte), .req_is_end(req_is_end),
      .empty(empty), .pop(pop), .rsp_out_byte(rsp_out_byte), .rsp_has_byte(rsp_has_byte),
      .rsp_error_code(rsp_error_code), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // cleaner state mirrored by the predictor
   logic [1:0]        m_qcnt;
   logic              m_bslash, m_space, m_slash, m_trigraph;
   clc_pkg::mode_type m_mode;
   logic [7:0]        m_quote;
   logic [1:0]        m_oct;
   clean_out_t        item_outs[$];
   clean_out_t        cleaned_q[$];
   int                errors = 0;
   int                rx_gap = 0;
   logic              rx_calm = 1'b0;

   task automatic report(input string what, input clean_out_t got, input clean_out_t want);
      $display("mismatch %s: got %h/%b/%0d/%b want %h/%b/%0d/%b", what, got.data, got.has,
               got.err, got.last, want.data, want.has, want.err, want.last);
      errors++;
   endtask

   function automatic void emit(logic [7:0] b, logic h, clc_pkg::err_type e);
      clean_out_t o;
      o.data = h ? b : 8'd0;
      o.has = h;
      o.err = e;
      o.last = 1'b0;
      if (item_outs.size() < clc_pkg::MaxResults) item_outs.push_back(o);
   endfunction

   function automatic void drain_normal();
      if (m_space) begin
         emit(clc_pkg::ChrSpace, 1'b1, clc_pkg::ERR_NONE);
         m_space = 1'b0;
      end
      if (m_slash) begin
         emit(clc_pkg::ChrSlash, 1'b1, clc_pkg::ERR_NONE);
         m_slash = 1'b0;
      end
   endfunction

   function automatic void in_literal(logic [7:0] c);
      if (c == m_quote) begin
         emit(c, 1'b1, clc_pkg::ERR_NONE);
         m_mode = clc_pkg::MODE_NORMAL;
      end else if (c == clc_pkg::ChrBslash) begin
         emit(c, 1'b1, clc_pkg::ERR_NONE);
         m_mode = clc_pkg::MODE_ESC;
      end else if (c == clc_pkg::ChrNewline) begin
         emit(c, 1'b1, clc_pkg::ERR_LITERAL);
         m_mode = clc_pkg::MODE_NORMAL;
      end else begin
         emit(c, 1'b1, clc_pkg::ERR_NONE);
      end
   endfunction

   function automatic void tokenize(logic [7:0] c_in);
      logic [7:0] c;
      c = (c_in == clc_pkg::ChrTab || c_in == clc_pkg::ChrVtab ||
           c_in == clc_pkg::ChrFormfeed) ? clc_pkg::ChrSpace : c_in;
      case (m_mode)
         clc_pkg::MODE_LITERAL: in_literal(c);
         clc_pkg::MODE_ESC: begin
            if (c == clc_pkg::ChrDquote || c == clc_pkg::ChrSquote ||
                c == clc_pkg::ChrQuestion || c == clc_pkg::ChrBslash ||
                c == "a" || c == "b" || c == "f" || c == "l" || c == "n" || c == "r" ||
                c == "t" || c == "v") begin
               emit(c, 1'b1, clc_pkg::ERR_NONE);
               m_mode = clc_pkg::MODE_LITERAL;
            end else if (c == "x") begin
               emit(c, 1'b1, clc_pkg::ERR_NONE);
               m_mode = clc_pkg::MODE_HEX;
            end else if (c == clc_pkg::ChrNewline) begin
               emit(c, 1'b1, clc_pkg::ERR_LITERAL);
               m_mode = clc_pkg::MODE_NORMAL;
            end else if (c >= "0" && c <= "7") begin
               emit(c, 1'b1, clc_pkg::ERR_NONE);
               m_oct = 2'd1;
               m_mode = clc_pkg::MODE_OCT;
            end else begin
               emit(c, 1'b1, clc_pkg::ERR_ESCAPE);
               m_mode = clc_pkg::MODE_LITERAL;
            end
         end
         clc_pkg::MODE_HEX: begin
            if ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
               emit(c, 1'b1, clc_pkg::ERR_NONE);
            else begin
               m_mode = clc_pkg::MODE_LITERAL;
               in_literal(c);
            end
         end
         clc_pkg::MODE_OCT: begin
            if (c >= "0" && c <= "7" && m_oct < 2'd3) begin
               emit(c, 1'b1, clc_pkg::ERR_NONE);
               m_oct++;
               if (m_oct == 2'd3) m_mode = clc_pkg::MODE_LITERAL;
            end else begin
               m_mode = clc_pkg::MODE_LITERAL;
               in_literal(c);
            end
         end
         clc_pkg::MODE_COMMENT: if (c == clc_pkg::ChrStar) m_mode = clc_pkg::MODE_STAR;
         clc_pkg::MODE_STAR: begin
            if (c == clc_pkg::ChrSlash) m_mode = clc_pkg::MODE_NORMAL;
            else if (c != clc_pkg::ChrStar) m_mode = clc_pkg::MODE_COMMENT;
         end
         default: begin
            m_mode = clc_pkg::MODE_NORMAL;
            if (m_slash && c == clc_pkg::ChrStar) begin
               m_slash = 1'b0;
               m_space = 1'b1;
               m_mode = clc_pkg::MODE_COMMENT;
            end else begin
               if (m_slash) drain_normal();
               if (c == clc_pkg::ChrSpace) m_space = 1'b1;
               else if (c == clc_pkg::ChrSlash) m_slash = 1'b1;
               else begin
                  drain_normal();
                  emit(c, 1'b1, clc_pkg::ERR_NONE);
                  if (c == clc_pkg::ChrDquote || c == clc_pkg::ChrSquote) begin
                     m_quote = c;
                     m_mode = clc_pkg::MODE_LITERAL;
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic void join_lines(logic [7:0] c);
      if (m_bslash) begin
         if (c == clc_pkg::ChrNewline) begin
            m_bslash = 1'b0;
            return;
         end
         tokenize(clc_pkg::ChrBslash);
         if (c == clc_pkg::ChrBslash) return;
         m_bslash = 1'b0;
      end
      if (c == clc_pkg::ChrBslash) m_bslash = 1'b1;
      else tokenize(c);
   endfunction

   function automatic logic [7:0] trigraph_of(logic [7:0] c);
      case (c)
         "=": return "#";
         "/": return clc_pkg::ChrBslash;
         "'": return "^";
         "(": return "[";
         ")": return "]";
         "!": return "|";
         "<": return "{";
         ">": return "}";
         "-": return "~";
         default: return 8'd0;
      endcase
   endfunction

   function automatic void clear_lexer();
      m_qcnt = 2'd0;
      m_bslash = 1'b0;
      m_mode = clc_pkg::MODE_NORMAL;
      m_quote = 8'd0;
      m_oct = 2'd0;
      m_space = 1'b0;
      m_slash = 1'b0;
   endfunction

   function automatic void predict_clean(logic [7:0] c, logic e);
      logic [7:0] rep;
      item_outs.delete();
      rep = trigraph_of(c);
      if (e) begin
         while (m_qcnt != 0) begin
            join_lines(clc_pkg::ChrQuestion);
            m_qcnt--;
         end
         m_bslash = 1'b0;
         if (m_mode == clc_pkg::MODE_NORMAL) drain_normal();
         if (m_mode == clc_pkg::MODE_COMMENT || m_mode == clc_pkg::MODE_STAR)
            emit(8'd0, 1'b0, clc_pkg::ERR_COMMENT);
         else if (m_mode != clc_pkg::MODE_NORMAL) emit(8'd0, 1'b0, clc_pkg::ERR_LITERAL);
         clear_lexer();
      end else if (m_trigraph && c == clc_pkg::ChrQuestion) begin
         if (m_qcnt < 2) m_qcnt++;
         else join_lines(clc_pkg::ChrQuestion);
      end else if (m_trigraph && m_qcnt == 2 && rep != 0) begin
         m_qcnt = 2'd0;
         join_lines(rep);
      end else begin
         while (m_qcnt != 0) begin
            join_lines(clc_pkg::ChrQuestion);
            m_qcnt--;
         end
         join_lines(c);
      end
      if (item_outs.size() > 0) item_outs[item_outs.size()-1].last = 1'b1;
   endfunction

   task automatic send(input logic [7:0] b, input logic e, input logic pinned,
                       input clean_out_t pin, input logic calm);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_in_byte <= b;
      req_is_end <= e;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_clean(b, e);
      if (pinned && (item_outs.size() != 1 || item_outs[0] != pin)) begin
         report("pinned row", item_outs.size() ? item_outs[0] : pin, pin);
      end
      foreach (item_outs[i]) cleaned_q.push_back(item_outs[i]);
   endtask

   task automatic write_trigraph(input logic v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      m_trigraph = v;
   endtask

   task automatic settle();
      push <= 1'b0;
      while (cleaned_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // result side: random pop stalls, checked against the oldest expectation
   always @(posedge clock) begin
      clean_out_t got;
      if (!reset) begin
         if (pop && !empty) begin
            got.data = rsp_out_byte;
            got.has = rsp_has_byte;
            got.err = clc_pkg::err_type'(rsp_error_code);
            got.last = rsp_last;
            if (cleaned_q.size() == 0) report("unexpected", got, got);
            else begin
               if (got != cleaned_q[0]) report("result", got, cleaned_q[0]);
               void'(cleaned_q.pop_front());
            end
         end
         if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            pop <= 1'b0;
         end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(1, 19);
            pop <= 1'b0;
         end else pop <= 1'b1;
      end
   end

   function automatic clean_out_t pin_of(logic [7:0] b, logic h, clc_pkg::err_type e);
      clean_out_t o;
      o.data = b;
      o.has = h;
      o.err = e;
      o.last = 1'b1;
      return o;
   endfunction

   function automatic logic [7:0] pick_byte();
      int k;
      k = $urandom_range(0, 19);
      case (k)
         0, 1: return clc_pkg::ChrQuestion;
         2: return clc_pkg::ChrBslash;
         3: return clc_pkg::ChrNewline;
         4: return clc_pkg::ChrSlash;
         5: return clc_pkg::ChrStar;
         6: return clc_pkg::ChrDquote;
         7: return clc_pkg::ChrSquote;
         8: return clc_pkg::ChrSpace;
         9: return "x";
         10: return 8'($urandom_range("0", "9"));
         11: return trigraph_of(8'($urandom_range(0, 255))) | "=";
         12: return 8'($urandom_range(9, 12));
         13: return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range("a", "z"));
      endcase
   endfunction

   stim_row_t directed[$];
   clean_out_t none_pin;

   initial begin
      int    total;
      string tri_chars;
      clear_lexer();
      m_trigraph = 1'b0;
      none_pin = pin_of(8'd0, 1'b0, clc_pkg::ERR_NONE);
      tri_chars = "=/'()!<>-";
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed = '{
         '{8'd0, 1'b0, 1'b1, pin_of(8'd0, 1'b1, clc_pkg::ERR_NONE)},
         '{8'hff, 1'b0, 1'b1, pin_of(8'hff, 1'b1, clc_pkg::ERR_NONE)},
         '{clc_pkg::ChrTab, 1'b0, 1'b0, none_pin},
         '{"a", 1'b0, 1'b0, none_pin},
         '{clc_pkg::ChrSlash, 1'b0, 1'b0, none_pin},
         '{clc_pkg::ChrStar, 1'b0, 1'b0, none_pin},
         '{clc_pkg::ChrNewline, 1'b0, 1'b0, none_pin},
         '{8'd0, 1'b1, 1'b1, pin_of(8'd0, 1'b0, clc_pkg::ERR_COMMENT)},
         '{clc_pkg::ChrDquote, 1'b0, 1'b1, pin_of(clc_pkg::ChrDquote, 1'b1, clc_pkg::ERR_NONE)},
         '{clc_pkg::ChrBslash, 1'b0, 1'b0, none_pin},
         '{"q", 1'b0, 1'b0, none_pin},
         '{clc_pkg::ChrBslash, 1'b0, 1'b0, none_pin},
         '{"x", 1'b0, 1'b0, none_pin},
         '{"F", 1'b0, 1'b0, none_pin},
         '{clc_pkg::ChrBslash, 1'b0, 1'b0, none_pin},
         '{"7", 1'b0, 1'b0, none_pin},
         '{"7", 1'b0, 1'b0, none_pin},
         '{"7", 1'b0, 1'b0, none_pin},
         '{"7", 1'b0, 1'b0, none_pin},
         '{clc_pkg::ChrNewline, 1'b0, 1'b1,
           pin_of(clc_pkg::ChrNewline, 1'b1, clc_pkg::ERR_LITERAL)},
         '{clc_pkg::ChrSquote, 1'b0, 1'b0, none_pin},
         '{8'hff, 1'b1, 1'b1, pin_of(8'd0, 1'b0, clc_pkg::ERR_LITERAL)},
         '{clc_pkg::ChrBslash, 1'b0, 1'b0, none_pin},
         '{clc_pkg::ChrNewline, 1'b0, 1'b0, none_pin},
         '{clc_pkg::ChrSpace, 1'b1, 1'b0, none_pin}
      };
      foreach (directed[i]) begin
         send(directed[i].in_byte, directed[i].is_end,
              directed[i].pinned, directed[i].pin, 1'b0);
      end
      settle();

      // trigraphs on: every form, overflow of question marks
      write_trigraph(1'b1);
      for (int i = 0; i < tri_chars.len(); i++) begin
         send(clc_pkg::ChrQuestion, 1'b0, 1'b0, none_pin, 1'b0);
         send(clc_pkg::ChrQuestion, 1'b0, 1'b0, none_pin, 1'b0);
         send(tri_chars[i], 1'b0, 1'b0, none_pin, 1'b0);
      end
      repeat (3) send(clc_pkg::ChrQuestion, 1'b0, 1'b0, none_pin, 1'b0);
      send(8'd0, 1'b1, 1'b0, none_pin, 1'b0);

      total = 0;
      for (int phase = 0; phase < 6; phase++) begin
         settle();
         write_trigraph(phase == 5 ? 1'b1 : 1'($urandom_range(0, 1)));
         for (int k = 0; k < 50; k++) begin
            if (phase == 5 && k == 25) rx_calm = 1'b1;
            send(pick_byte(), $urandom_range(0, 29) == 0, 1'b0, none_pin, rx_calm);
            total++;
         end
         send(8'd0, 1'b1, 1'b0, none_pin, rx_calm);
      end
      settle();
      repeat (20) @(posedge clock);
      if (errors == 0 && cleaned_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
